/* sv/mi3_pkg.sv */
`timescale 1ns / 1ps

package mi3_pkg;

  localparam int unsigned NumEntries = 9;
  localparam int unsigned EntryW     = 16;
  localparam int unsigned ResultW    = 32;

  typedef struct packed {
    logic signed [EntryW-1:0] entry_value;
    logic                     entry_last;
  } entry_t;

  typedef struct packed {
    logic signed [ResultW-1:0] inverse_entry;
    logic signed [ResultW-1:0] determinant_value;
    logic                      is_singular;
    logic                      result_last;
  } result_t;

  typedef logic [NumEntries-1:0][EntryW-1:0] matrix_t;

  typedef struct packed {
    logic    valid;
    matrix_t mat;
  } mat_req_t;

  // adjugate entry k = m[A1]*m[B1] - m[A2]*m[B2]
  localparam logic [3:0] AdjA1 [NumEntries] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] AdjB1 [NumEntries] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] AdjA2 [NumEntries] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] AdjB2 [NumEntries] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

/* sv/matrix_inverse_3x3.sv */
`timescale 1ns / 1ps

// 3x3 matrix inverse by adjugate over determinant.
// Input: raise start_i with req_i (Q8.8 entry, last mark); a request is taken
// at a clock edge with start_i high and busy_o low. Entries fill positions
// 0..8 in order; further entries without a last mark are dropped. The request
// marked last snapshots the matrix into a one-deep queue and busy_o rises
// until the compute engine takes it, which is the next cycle when it is idle.
// Output: nine results, one cycle each on res_o with res_valid_o high, in
// storage order; result_last marks the ninth. The receiver cannot stall.
// The adjugate and then the determinant are formed over one shared
// multiplier, the determinant is checked, then each entry takes a setup, a
// 58-step divider and an emit. A singular matrix skips the divider and emits
// zero results. Loading the next matrix overlaps the current run.
// Reset clears the load count, queue and engine; the entry store is undefined
// until written.
module matrix_inverse_3x3 (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mi3_pkg::entry_t  req_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output mi3_pkg::result_t res_o
);

  mi3_pkg::mat_req_t mat;
  logic              pop;

  mi3_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .pop_i  (pop),
    .mat_o  (mat)
  );

  mi3_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mat_i      (mat),
    .pop_o      (pop),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

/* sv/mi3_front.sv */
`timescale 1ns / 1ps

module mi3_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mi3_pkg::entry_t   req_i,
  output logic              busy_o,
  input  logic              pop_i,
  output mi3_pkg::mat_req_t mat_o
);

  logic [3:0]       load_count_q, load_count_d;
  mi3_pkg::matrix_t store_q, store_d;
  logic             qvalid_q;
  mi3_pkg::matrix_t qmat_q;
  logic             accept;

  assign accept = start_i && !qvalid_q;
  assign busy_o = qvalid_q;

  always_comb begin
    store_d      = store_q;
    load_count_d = load_count_q;
    if (accept) begin
      if (load_count_q < 4'(mi3_pkg::NumEntries)) begin
        store_d[load_count_q] = req_i.entry_value;
        load_count_d          = load_count_q + 4'd1;
      end
      if (req_i.entry_last) begin
        load_count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      qvalid_q     <= 1'b0;
    end else begin
      load_count_q <= load_count_d;
      if (accept && req_i.entry_last) begin
        qvalid_q <= 1'b1;
      end else if (pop_i) begin
        qvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    if (accept && req_i.entry_last) begin
      qmat_q <= store_d;
    end
  end

  assign mat_o.valid = qvalid_q;
  assign mat_o.mat   = qmat_q;

endmodule

/* sv/mi3_back.sv */
`timescale 1ns / 1ps

module mi3_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mi3_pkg::mat_req_t mat_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output mi3_pkg::result_t  res_o
);

  localparam int unsigned ProdW = 49;
  localparam int unsigned AdjW  = 33;
  localparam int unsigned DetW  = 51;
  localparam int unsigned NumW  = 58;
  localparam int unsigned RemW  = 52;

  typedef enum logic [2:0] {
    S_IDLE, S_ADJ, S_DET, S_CHECK, S_DIVINIT, S_DIV, S_EMIT, S_ZERO
  } state_e;

  state_e                  state_q;
  logic [3:0]              k_q;
  logic [1:0]              ph_q;
  logic [5:0]              cnt_q;
  logic signed [15:0]      m_q [mi3_pkg::NumEntries];
  logic signed [AdjW-1:0]  adj_q [mi3_pkg::NumEntries];
  logic signed [AdjW-1:0]  t_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [DetW-1:0]  det_q;
  logic [DetW-1:0]         dmag_q;
  logic [31:0]             detq_q;
  logic [NumW-1:0]         num_q;
  logic [RemW-1:0]         rem_q;
  logic                    neg_q;
  logic signed [15:0]      op_a;
  logic signed [AdjW-1:0]  op_b;
  logic [3:0]              didx;
  logic [RemW-1:0]         rs;
  logic                    ge;
  logic [AdjW-1:0]         amag;
  logic [DetW-1:0]         dmag;
  logic [DetW-1:0]         drnd;

  function automatic logic [31:0] sat32(input logic [NumW-1:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (q > NumW'(33'h080000000)) ? 32'h80000000 : 32'(-q);
    end else begin
      r = (q > NumW'(32'h7fffffff)) ? 32'h7fffffff : q[31:0];
    end
    return r;
  endfunction

  assign pop_o = (state_q == S_IDLE) && mat_i.valid;
  assign didx  = (k_q == 4'd0) ? 4'd0 : ((k_q == 4'd1) ? 4'd3 : 4'd6);

  always_comb begin
    op_a = m_q[mi3_pkg::AdjA1[k_q]];
    op_b = AdjW'(m_q[mi3_pkg::AdjB1[k_q]]);
    if (state_q == S_ADJ && ph_q == 2'd1) begin
      op_a = m_q[mi3_pkg::AdjA2[k_q]];
      op_b = AdjW'(m_q[mi3_pkg::AdjB2[k_q]]);
    end else if (state_q == S_DET) begin
      op_a = m_q[k_q];
      op_b = adj_q[didx];
    end
  end

  assign rs   = {rem_q[RemW-2:0], num_q[NumW-1]};
  assign ge   = rs >= {1'b0, dmag_q};
  assign amag = adj_q[k_q][AdjW-1] ? AdjW'(-adj_q[k_q]) : AdjW'(adj_q[k_q]);
  assign dmag = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);
  assign drnd = (dmag + DetW'(128)) >> 8;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      ph_q        <= '0;
      cnt_q       <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            for (int i = 0; i < mi3_pkg::NumEntries; i++) begin
              m_q[i] <= $signed(mat_i.mat[i]);
            end
            k_q     <= '0;
            ph_q    <= '0;
            state_q <= S_ADJ;
          end
        end
        S_ADJ: begin
          unique case (ph_q)
            2'd0: ph_q <= 2'd1;
            2'd1: begin
              t_q  <= AdjW'(prod_q);
              ph_q <= 2'd2;
            end
            default: begin
              adj_q[k_q] <= t_q - AdjW'(prod_q);
              ph_q       <= '0;
              if (k_q == 4'(mi3_pkg::NumEntries - 1)) begin
                k_q     <= '0;
                det_q   <= '0;
                state_q <= S_DET;
              end else begin
                k_q <= k_q + 4'd1;
              end
            end
          endcase
        end
        S_DET: begin
          if (ph_q == 2'd0) begin
            ph_q <= 2'd1;
          end else begin
            det_q <= det_q + DetW'(prod_q);
            ph_q  <= '0;
            if (k_q == 4'd2) begin
              k_q     <= '0;
              state_q <= S_CHECK;
            end else begin
              k_q <= k_q + 4'd1;
            end
          end
        end
        S_CHECK: begin
          dmag_q <= dmag;
          detq_q <= sat32(NumW'(drnd), det_q[DetW-1]);
          if (det_q == '0) begin
            state_q <= S_ZERO;
          end else begin
            state_q <= S_DIVINIT;
          end
        end
        S_DIVINIT: begin
          num_q   <= NumW'({amag, 24'b0}) + NumW'(dmag_q >> 1);
          rem_q   <= '0;
          neg_q   <= adj_q[k_q][AdjW-1] ^ det_q[DetW-1];
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= ge ? RemW'(rs - {1'b0, dmag_q}) : rs;
          num_q <= {num_q[NumW-2:0], ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(NumW - 1)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          res_valid_o             <= 1'b1;
          res_o.inverse_entry     <= sat32(num_q, neg_q);
          res_o.determinant_value <= detq_q;
          res_o.is_singular       <= 1'b0;
          res_o.result_last       <= (k_q == 4'(mi3_pkg::NumEntries - 1));
          if (k_q == 4'(mi3_pkg::NumEntries - 1)) begin
            state_q <= S_IDLE;
          end else begin
            k_q     <= k_q + 4'd1;
            state_q <= S_DIVINIT;
          end
        end
        S_ZERO: begin
          res_valid_o             <= 1'b1;
          res_o.inverse_entry     <= '0;
          res_o.determinant_value <= '0;
          res_o.is_singular       <= 1'b1;
          res_o.result_last       <= (k_q == 4'(mi3_pkg::NumEntries - 1));
          if (k_q == 4'(mi3_pkg::NumEntries - 1)) begin
            state_q <= S_IDLE;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.is_singular |-> res_o.inverse_entry == '0)
    else $error("singular result carries nonzero entry");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.result_last |-> state_q == S_IDLE)
    else $error("last result while still running");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < {1'b0, dmag_q})
    else $error("divider remainder out of range");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_ADJ && !res_valid_o)
    else $error("pop did not start a run");

endmodule

/* test/matrix_inverse_3x3_tb.sv */
`timescale 1ns / 1ps

module matrix_inverse_3x3_tb;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 800;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  mi3_pkg::entry_t  req_i;
  logic             busy_o;
  logic             res_valid_o;
  mi3_pkg::result_t res_o;

  matrix_inverse_3x3 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  mi3_pkg::entry_t  pending_q[$];
  mi3_pkg::result_t inverse_q[$];
  logic signed [15:0] mat_store [mi3_pkg::NumEntries];
  int unsigned load_cnt;
  int unsigned idle_left;
  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  int unsigned total_items;
  bit          failed;
  bit          drain_en;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint div_round_sat(longint num, longint den);
    longint n, d, q;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n + d / 2) / d;
    if ((num < 0) != (den < 0)) begin
      if (q > 64'sh80000000) return -64'sh80000000;
      return -q;
    end
    if (q > 64'sh7fffffff) return 64'sh7fffffff;
    return q;
  endfunction

  task automatic predict_inverse(mi3_pkg::entry_t e);
    longint m [9];
    longint adj [9];
    longint det, detq;
    mi3_pkg::result_t r;
    if (load_cnt < mi3_pkg::NumEntries) begin
      mat_store[load_cnt] = e.entry_value;
      load_cnt++;
    end
    if (!e.entry_last) return;
    load_cnt = 0;
    for (int i = 0; i < 9; i++) m[i] = longint'(mat_store[i]);
    adj[0] = m[4] * m[8] - m[5] * m[7];
    adj[1] = m[2] * m[7] - m[1] * m[8];
    adj[2] = m[1] * m[5] - m[2] * m[4];
    adj[3] = m[5] * m[6] - m[3] * m[8];
    adj[4] = m[0] * m[8] - m[2] * m[6];
    adj[5] = m[2] * m[3] - m[0] * m[5];
    adj[6] = m[3] * m[7] - m[4] * m[6];
    adj[7] = m[1] * m[6] - m[0] * m[7];
    adj[8] = m[0] * m[4] - m[1] * m[3];
    det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
    detq = (det == 0) ? 0 : div_round_sat(det, 256);
    for (int k = 0; k < 9; k++) begin
      r.inverse_entry = (det == 0) ? 32'sd0 : 32'(div_round_sat(adj[k] * (64'sd1 << 24), det));
      r.determinant_value = 32'(detq);
      r.is_singular = (det == 0);
      r.result_last = (k == 8);
      inverse_q.push_back(r);
    end
  endtask

  function automatic logic signed [15:0] rand_entry(int unsigned mode);
    case (mode)
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 1024)) - 512);
      3: return 16'(int'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_matrix(logic signed [15:0] v [9]);
    mi3_pkg::entry_t e;
    for (int i = 0; i < 9; i++) begin
      e.entry_value = v[i];
      e.entry_last = (i == 8);
      pending_q.push_back(e);
    end
  endtask

  initial begin
    logic signed [15:0] v [9];
    mi3_pkg::entry_t e;
    int unsigned mode, n;
    for (int i = 0; i < 9; i++) v[i] = 16'sd0;
    v[0] = 16'sd256; v[4] = 16'sd256; v[8] = 16'sd256;
    push_matrix(v);
    v[4] = 16'sd512; v[2] = 16'sd256;
    push_matrix(v);
    for (int i = 0; i < 9; i++) v[i] = 16'sd256;
    push_matrix(v);
    for (int i = 0; i < 9; i++) v[i] = 16'sd0;
    v[0] = 16'sh7fff; v[4] = 16'sh8000; v[8] = 16'sd1;
    v[1] = 16'sh8000; v[5] = 16'sh7fff;
    push_matrix(v);
    for (int i = 0; i < 9; i++) v[i] = 16'sd0;
    v[0] = 16'sd1; v[4] = 16'sd1; v[8] = 16'sd1;
    push_matrix(v);
    for (int i = 0; i < 9; i++) begin
      e.entry_value = 16'sd300 + 16'(i);
      e.entry_last = 1'b0;
      pending_q.push_back(e);
    end
    e.entry_value = 16'sh7fff;
    pending_q.push_back(e);
    e.entry_value = 16'sd7;
    e.entry_last = 1'b1;
    pending_q.push_back(e);
    e.entry_value = 16'sh8000;
    pending_q.push_back(e);
    while (pending_q.size() < 270) begin
      n = $urandom_range(0, 9);
      if (n < 8) begin
        mode = $urandom_range(0, 4);
        for (int i = 0; i < 9; i++)
          v[i] = ($urandom_range(0, 5) == 0) ? rand_entry($urandom_range(0, 1)) :
                 rand_entry(mode);
        if ($urandom_range(0, 5) == 0) v[$urandom_range(3, 5)] = v[$urandom_range(0, 2)];
        push_matrix(v);
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          e.entry_value = rand_entry($urandom_range(0, 4));
          e.entry_last = (i == n - 1);
          pending_q.push_back(e);
        end
      end
    end
    total_items = pending_q.size();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i   <= 1'b0;
      req_i     <= '0;
      idle_left <= 0;
      sent_cnt  <= 0;
    end else begin
      if (start_i && !busy_o) begin
        predict_inverse(req_i);
        sent_cnt <= sent_cnt + 1;
      end
      if (start_i && busy_o) begin
        // hold
      end else if (idle_left != 0) begin
        start_i   <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_q.size() != 0 &&
                   (pending_q.size() < 40 || $urandom_range(0, 7) != 0)) begin
        start_i <= 1'b1;
        req_i   <= pending_q.pop_front();
      end else begin
        start_i <= 1'b0;
        if (pending_q.size() != 0) idle_left <= $urandom_range(0, 5);
      end
    end
  end

  always @(posedge clk_i) begin
    mi3_pkg::result_t x;
    if (rst_ni && res_valid_o) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        failed <= 1'b1;
      end else begin
        x = inverse_q.pop_front();
        if (res_o !== x) begin
          $display("%0t: expected inv %h det %h sing %b last %b, %s",
                   $time, x.inverse_entry, x.determinant_value, x.is_singular,
                   x.result_last, "actual:");
          $display("%0t:   actual inv %h det %h sing %b last %b",
                   $time, res_o.inverse_entry, res_o.determinant_value,
                   res_o.is_singular, res_o.result_last);
          failed <= 1'b1;
        end
      end
    end
  end

  initial begin
    failed    = 1'b0;
    load_cnt  = 0;
    cycle_cnt = 0;
    rst_ni    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(total_items != 0 && sent_cnt == total_items && inverse_q.size() == 0)) begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed && inverse_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
